// ===== sv/mpwa_pkg.sv =====
// Shared types and constants for the max pooling argmax block.
// Used by the front end, the command queue, the back end and the top level.
package mpwa_pkg;

    // Default sizes of the frame store and the window.
    localparam int CHANNELS_DEF   = 16;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_KERNEL_DEF = 8;

    // Fixed widths set by the channel fields.
    localparam int SAMPLE_BITS = 16;
    localparam int CHAN_W      = 8;   // wide enough for any channel count up to 256
    localparam int COORD_W     = 13;  // signed window origin, row * stride - pad
    localparam int DIM_W       = 11;  // clamped input size, up to 1024
    localparam int QUEUE_DEPTH = 2;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_IN_HEIGHT     = 3'd0;
    localparam logic [2:0] REG_IN_WIDTH      = 3'd1;
    localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd2;
    localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd3;
    localparam logic [2:0] REG_STRIDE_ROWS   = 3'd4;
    localparam logic [2:0] REG_STRIDE_COLS   = 3'd5;
    localparam logic [2:0] REG_PAD_ROWS      = 3'd6;
    localparam logic [2:0] REG_PAD_COLS      = 3'd7;

    // Configuration register file.
    typedef struct packed {
        logic [6:0] in_height;
        logic [6:0] in_width;
        logic [3:0] kernel_height;
        logic [3:0] kernel_width;
        logic [3:0] stride_rows;
        logic [3:0] stride_cols;
        logic [2:0] pad_rows;
        logic [2:0] pad_cols;
    } cfg_t;

    // One classified command in the queue. For a write, row0 and col0 hold the
    // target row and column; for a query they hold the signed window origin.
    typedef struct packed {
        logic                   is_query;
        logic                   valid;
        logic [CHAN_W-1:0]      chan;
        logic [COORD_W-1:0]     row0;
        logic [COORD_W-1:0]     col0;
        logic [SAMPLE_BITS-1:0] sample;
    } entry_t;

endpackage

// ===== sv/mpwa_front.sv =====
// Front end: takes input items, checks their range and works out window origins.
// Depends on mpwa_pkg for the entry and configuration types.
module mpwa_front #(
    parameter int CHANNELS   = mpwa_pkg::CHANNELS_DEF,
    parameter int MAX_HEIGHT = mpwa_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = mpwa_pkg::MAX_WIDTH_DEF
) (
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  logic [3:0]             s_channel,
    input  logic [6:0]             s_row,
    input  logic [6:0]             s_col,
    input  logic signed [15:0]     s_sample,
    input  mpwa_pkg::cfg_t         cfg,
    input  logic                   q_full,
    output logic                   q_push,
    output mpwa_pkg::entry_t       q_entry
);

    logic [10:0] row_prod;
    logic [10:0] col_prod;
    logic        chan_ok;
    logic        write_ok;

    // The queue takes a transfer whenever it has room.
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Window origin of a query: output coordinate times stride minus padding.
    assign row_prod = 11'(s_row) * 11'(cfg.stride_rows);
    assign col_prod = 11'(s_col) * 11'(cfg.stride_cols);

    // Writes outside the store are dropped; queries on a missing channel are empty.
    assign chan_ok  = 32'(s_channel) < CHANNELS;
    assign write_ok = chan_ok && (32'(s_row) < MAX_HEIGHT) && (32'(s_col) < MAX_WIDTH);

    always_comb begin
        q_entry          = '0;
        q_entry.is_query = (s_command == mpwa_pkg::CMD_QUERY);
        q_entry.chan     = mpwa_pkg::CHAN_W'(s_channel);
        q_entry.sample   = s_sample;
        if (s_command == mpwa_pkg::CMD_QUERY) begin
            q_entry.valid = chan_ok;
            q_entry.row0  = mpwa_pkg::COORD_W'(row_prod) - mpwa_pkg::COORD_W'(cfg.pad_rows);
            q_entry.col0  = mpwa_pkg::COORD_W'(col_prod) - mpwa_pkg::COORD_W'(cfg.pad_cols);
        end else begin
            q_entry.valid = write_ok;
            q_entry.row0  = mpwa_pkg::COORD_W'(s_row);
            q_entry.col0  = mpwa_pkg::COORD_W'(s_col);
        end
    end

endmodule

// ===== sv/mpwa_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on mpwa_pkg for the entry type and the queue depth.
module mpwa_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  mpwa_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output mpwa_pkg::entry_t head_entry
);

    localparam int PTR_W = (mpwa_pkg::QUEUE_DEPTH > 1) ? $clog2(mpwa_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mpwa_pkg::QUEUE_DEPTH + 1);

    mpwa_pkg::entry_t slots_reg [mpwa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(mpwa_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];

    // Pointer and fill count update with wrap at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(mpwa_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(mpwa_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/mpwa_back.sv =====
// Back end: owns the frame store, performs writes and walks query windows.
// Depends on mpwa_pkg for the entry and configuration types.
module mpwa_back #(
    parameter int CHANNELS   = mpwa_pkg::CHANNELS_DEF,
    parameter int MAX_HEIGHT = mpwa_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = mpwa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = mpwa_pkg::MAX_KERNEL_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mpwa_pkg::cfg_t        cfg,
    input  logic                  q_valid,
    input  mpwa_pkg::entry_t      q_entry,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_max_value,
    output logic [5:0]            m_arg_row,
    output logic [5:0]            m_arg_col,
    output logic                  m_empty_window
);

    localparam int CHB    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RB     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CB     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ADDR_W = CHB + RB + CB;
    localparam int KCNT_W = $clog2(MAX_KERNEL + 1);
    localparam int CW     = mpwa_pkg::COORD_W;
    localparam int SB     = mpwa_pkg::SAMPLE_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [SB-1:0]     store [2**ADDR_W];

    logic [1:0]        state_reg, state_next;
    mpwa_pkg::entry_t  cur_reg, cur_next;
    logic [KCNT_W-1:0] x_reg, x_next;
    logic [KCNT_W-1:0] y_reg, y_next;
    logic              found_reg, found_next;
    logic signed [SB-1:0] best_reg, best_next;
    logic [5:0]        best_r_reg, best_r_next;
    logic [5:0]        best_c_reg, best_c_next;
    logic              rd_vld_reg;
    logic [SB-1:0]     rd_data_reg;
    logic [5:0]        rd_r_reg;
    logic [5:0]        rd_c_reg;
    logic              m_valid_reg, m_valid_next;
    logic signed [15:0] m_max_reg;
    logic [5:0]        m_row_reg;
    logic [5:0]        m_col_reg;
    logic              m_empty_reg;

    logic [mpwa_pkg::DIM_W-1:0] ih, iw;
    logic [KCNT_W-1:0] kh, kw;
    logic signed [CW-1:0] rr, cc;
    logic              in_box;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              load;
    logic              start;

    // Sizes saturated to what the store and the walk counters hold.
    assign ih = (32'(cfg.in_height) > MAX_HEIGHT) ? mpwa_pkg::DIM_W'(MAX_HEIGHT)
                                                  : mpwa_pkg::DIM_W'(cfg.in_height);
    assign iw = (32'(cfg.in_width) > MAX_WIDTH) ? mpwa_pkg::DIM_W'(MAX_WIDTH)
                                                : mpwa_pkg::DIM_W'(cfg.in_width);
    assign kh = (32'(cfg.kernel_height) > MAX_KERNEL) ? KCNT_W'(MAX_KERNEL)
                                                      : KCNT_W'(cfg.kernel_height);
    assign kw = (32'(cfg.kernel_width) > MAX_KERNEL) ? KCNT_W'(MAX_KERNEL)
                                                     : KCNT_W'(cfg.kernel_width);

    // Current window position and whether it lies inside the input.
    assign rr = $signed(cur_reg.row0) + $signed(CW'(x_reg));
    assign cc = $signed(cur_reg.col0) + $signed(CW'(y_reg));
    assign in_box = !rr[CW-1] && (rr < $signed(CW'(ih)))
                 && !cc[CW-1] && (cc < $signed(CW'(iw)));
    assign rd_en   = (state_reg == ST_WALK) && in_box;
    assign rd_addr = {cur_reg.chan[CHB-1:0], rr[RB-1:0], cc[CB-1:0]};

    // Writes are carried out as they leave the queue.
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign wr_en   = q_pop && !q_entry.is_query && q_entry.valid;
    assign wr_addr = {q_entry.chan[CHB-1:0], q_entry.row0[RB-1:0], q_entry.col0[CB-1:0]};
    assign start   = q_pop && q_entry.is_query;

    assign load = (state_reg == ST_RESULT) && (!m_valid_reg || m_ready);

    // Walk sequencer.
    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cur_next = q_entry;
                    x_next   = '0;
                    y_next   = '0;
                    if (q_entry.valid && (kh != '0) && (kw != '0)) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_WALK: begin
                if (y_reg == kw - 1'b1) begin
                    y_next = '0;
                    if (x_reg == kh - 1'b1) begin
                        state_next = ST_DRAIN;
                    end else begin
                        x_next = x_reg + 1'b1;
                    end
                end else begin
                    y_next = y_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (load) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Running maximum; ties keep the earlier position.
    always_comb begin
        found_next  = found_reg;
        best_next   = best_reg;
        best_r_next = best_r_reg;
        best_c_next = best_c_reg;
        if (start) begin
            found_next  = 1'b0;
            best_next   = {1'b1, {(SB-1){1'b0}}};
            best_r_next = '0;
            best_c_next = '0;
        end else if (rd_vld_reg && (!found_reg || $signed(rd_data_reg) > best_reg)) begin
            found_next  = 1'b1;
            best_next   = $signed(rd_data_reg);
            best_r_next = rd_r_reg;
            best_c_next = rd_c_reg;
        end
    end

    // Output register: a finished result waits here while the back end moves on.
    assign m_valid_next = (m_valid_reg && !m_ready) || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_en;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        best_r_reg <= best_r_next;
        best_c_reg <= best_c_next;
        rd_r_reg   <= rr[5:0];
        rd_c_reg   <= cc[5:0];
        if (load) begin
            m_max_reg   <= 16'(best_reg);
            m_row_reg   <= best_r_reg;
            m_col_reg   <= best_c_reg;
            m_empty_reg <= !found_reg;
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_addr] <= q_entry.sample;
        end
        rd_data_reg <= store[rd_addr];
    end

    assign m_valid        = m_valid_reg;
    assign m_max_value    = m_max_reg;
    assign m_arg_row      = m_row_reg;
    assign m_arg_col      = m_col_reg;
    assign m_empty_window = m_empty_reg;

    // The queue is drained only while no query is in progress.
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_IDLE)
        else $error("queue popped during a window walk");

    // A store read issued in the walk is consumed before the drain ends.
    a_read_window: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (state_reg == ST_WALK || state_reg == ST_DRAIN))
        else $error("store read data pending outside the walk");

    // The result is never taken with a compare still outstanding.
    a_result_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RESULT |-> !rd_vld_reg)
        else $error("result loaded before the last compare");

    // A result only appears after a query was started.
    a_load_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_RESULT)
        else $error("result valid without a finished query");

endmodule

// ===== sv/max_pool_window_argmax.sv =====
// Max pooling with argmax: top level with the configuration registers.
// Instantiates mpwa_front, mpwa_fifo and mpwa_back; uses mpwa_pkg.
//
// Input channel (s_valid/s_ready): command 0 writes s_sample into the frame
// store at s_channel, s_row, s_col; command 1 queries the pooled output at
// output position s_row, s_col of s_channel. A write gives no result; a query
// gives one transfer on the result channel (m_valid/m_ready) holding the
// window maximum, the row and column of its first occurrence in row-major
// order, and an empty flag when no window position lies inside the input.
// The back end takes a new command only while idle. A write is stored as it
// leaves the queue; a query walks the window one position a cycle through the
// single read port of the frame store, then passes a drain state and a result
// state that waits for the output register to be free.
// A two-entry queue lets the input side keep accepting while the back end
// walks a window or a result waits; when the receiver stalls, the result
// holds in the output register and the queue fills, then s_ready drops.
// Reset: configuration returns to 64x64 input, 2x2 kernel, stride 2, no
// padding, and the queue empties. The frame store is not cleared; a window
// covering a never-written entry returns undefined data.
// The user writes configuration (cfg_we, cfg_index, cfg_wdata) only while
// idle; the block itself does not enforce this.
module max_pool_window_argmax #(
    parameter int CHANNELS   = mpwa_pkg::CHANNELS_DEF,
    parameter int MAX_HEIGHT = mpwa_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = mpwa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = mpwa_pkg::MAX_KERNEL_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [6:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [3:0]         s_channel,
    input  logic [6:0]         s_row,
    input  logic [6:0]         s_col,
    input  logic signed [15:0] s_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_max_value,
    output logic [5:0]         m_arg_row,
    output logic [5:0]         m_arg_col,
    output logic               m_empty_window
);

    mpwa_pkg::cfg_t   cfg_reg, cfg_next;
    logic             q_full;
    logic             q_push;
    mpwa_pkg::entry_t q_in;
    logic             q_pop;
    logic             q_valid;
    mpwa_pkg::entry_t q_head;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                mpwa_pkg::REG_IN_HEIGHT:     cfg_next.in_height     = cfg_wdata;
                mpwa_pkg::REG_IN_WIDTH:      cfg_next.in_width      = cfg_wdata;
                mpwa_pkg::REG_KERNEL_HEIGHT: cfg_next.kernel_height = cfg_wdata[3:0];
                mpwa_pkg::REG_KERNEL_WIDTH:  cfg_next.kernel_width  = cfg_wdata[3:0];
                mpwa_pkg::REG_STRIDE_ROWS:   cfg_next.stride_rows   = cfg_wdata[3:0];
                mpwa_pkg::REG_STRIDE_COLS:   cfg_next.stride_cols   = cfg_wdata[3:0];
                mpwa_pkg::REG_PAD_ROWS:      cfg_next.pad_rows      = cfg_wdata[2:0];
                mpwa_pkg::REG_PAD_COLS:      cfg_next.pad_cols      = cfg_wdata[2:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_height     <= 7'd64;
            cfg_reg.in_width      <= 7'd64;
            cfg_reg.kernel_height <= 4'd2;
            cfg_reg.kernel_width  <= 4'd2;
            cfg_reg.stride_rows   <= 4'd2;
            cfg_reg.stride_cols   <= 4'd2;
            cfg_reg.pad_rows      <= 3'd0;
            cfg_reg.pad_cols      <= 3'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mpwa_front #(
        .CHANNELS   (CHANNELS),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_channel (s_channel),
        .s_row     (s_row),
        .s_col     (s_col),
        .s_sample  (s_sample),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    mpwa_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    mpwa_back #(
        .CHANNELS   (CHANNELS),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_entry        (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_max_value    (m_max_value),
        .m_arg_row      (m_arg_row),
        .m_arg_col      (m_arg_col),
        .m_empty_window (m_empty_window)
    );

endmodule
